@@ src/gha_pkg.sv @@
// Shared constants, codes and controller/datapath interface types for the handle allocator.
package gha_pkg;

    localparam int SLOTS       = 256;
    localparam int SLOT_W      = $clog2(SLOTS);
    localparam int DEPTH_W     = SLOT_W + 1;
    localparam int GEN_BITS    = 16;
    localparam int OP_W        = 3;
    localparam int SLOT_FLD_W  = 9;
    localparam int GEN_FLD_W   = 16;
    localparam int STAT_W      = 2;

    localparam logic [OP_W-1:0] OP_CREATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_RESERVE  = 3'd1;
    localparam logic [OP_W-1:0] OP_DESTROY  = 3'd2;
    localparam logic [OP_W-1:0] OP_READY    = 3'd3;
    localparam logic [OP_W-1:0] OP_VALID    = 3'd4;
    localparam logic [OP_W-1:0] OP_GET      = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd2;

    localparam logic [SLOT_FLD_W-1:0] INVALID_SLOT = SLOT_FLD_W'(SLOTS);
    localparam logic [DEPTH_W-1:0]    FULL_DEPTH   = DEPTH_W'(SLOTS);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;      // capture the input word, launch first memory reads
        logic pop;         // pop the free stack, launch generation read at popped slot
        logic finish_a;    // finish a single-pass operation
        logic finish_b;    // finish a create after the popped slot's generation read
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic pop_go;      // latched op is a create and the free stack is not empty
    } t_stat;

endpackage

@@ src/generational_handle_allocator_core.sv @@
// Top level of the generational handle allocator: controller plus datapath.
//
//  Channel   Handshake            Word
//  -------   ------------------   ------------------------------------------------
//  command   start / busy         i_op, i_slot, i_handle_generation
//  result    o_strobe (1 cycle)   o_result_slot, o_result_generation, o_answer,
//                                 o_status
//
// Flow: a command is taken when start is high and busy is low. Destroy, checks,
// get and a create on an empty stack hold busy through one generation RAM read;
// create and create reserved with a free slot hold it through a stack RAM read,
// then a generation RAM read at the popped slot.
// The result word shows in the first cycle with busy low, exactly one cycle long;
// the receiver cannot stall it, and a new command may be taken in that cycle.
// Reset (synchronous, active low) empties nothing: the free stack starts full
// with slot 0 on top, all generations zero, no slot alive. No clearing pass.
// Unpushed stack entries are served from a low-water mark; each slot's alive bit
// sits beside its generation, and unwritten entries read as zero through per-slot
// written flags.
module generational_handle_allocator_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [gha_pkg::OP_W-1:0]          i_op,
    input  logic [gha_pkg::SLOT_FLD_W-1:0]    i_slot,
    input  logic [gha_pkg::GEN_FLD_W-1:0]     i_handle_generation,
    output logic                              o_strobe,
    output logic [gha_pkg::SLOT_FLD_W-1:0]    o_result_slot,
    output logic [gha_pkg::GEN_FLD_W-1:0]     o_result_generation,
    output logic                              o_answer,
    output logic [gha_pkg::STAT_W-1:0]        o_status
);
    import gha_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    gha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_stat  (stat),
        .o_cmd   (cmd),
        .busy    (busy)
    );

    gha_datapath u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .o_stat              (stat),
        .i_op                (i_op),
        .i_slot              (i_slot),
        .i_handle_generation (i_handle_generation),
        .o_strobe            (o_strobe),
        .o_result_slot       (o_result_slot),
        .o_result_generation (o_result_generation),
        .o_answer            (o_answer),
        .o_status            (o_status)
    );

endmodule

@@ src/gha_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module gha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ src/gha_ctrl.sv @@
// Controller state machine for the handle allocator.
module gha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    input  gha_pkg::t_stat i_stat,
    output gha_pkg::t_cmd  o_cmd,
    output logic          busy
);
    import gha_pkg::*;

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_FIRST  = 2'd1;
    localparam logic [1:0] S_SECOND = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state         = r_state;
        o_cmd           = '0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.accept = 1'b1;
                    n_state      = S_FIRST;
                end
            end
            S_FIRST: begin
                if (i_stat.pop_go) begin
                    o_cmd.pop = 1'b1;
                    n_state   = S_SECOND;
                end else begin
                    o_cmd.finish_a = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_SECOND: begin
                o_cmd.finish_b = 1'b1;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != S_IDLE);

endmodule

@@ src/gha_datapath.sv @@
// Datapath: free stack, generation store with alive bits, and result registers.
module gha_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  gha_pkg::t_cmd                     i_cmd,
    output gha_pkg::t_stat                    o_stat,
    input  logic [gha_pkg::OP_W-1:0]          i_op,
    input  logic [gha_pkg::SLOT_FLD_W-1:0]    i_slot,
    input  logic [gha_pkg::GEN_FLD_W-1:0]     i_handle_generation,
    output logic                              o_strobe,
    output logic [gha_pkg::SLOT_FLD_W-1:0]    o_result_slot,
    output logic [gha_pkg::GEN_FLD_W-1:0]     o_result_generation,
    output logic                              o_answer,
    output logic [gha_pkg::STAT_W-1:0]        o_status
);
    import gha_pkg::*;

    // Latched input word
    logic [OP_W-1:0]       r_op;
    logic [SLOT_FLD_W-1:0] r_slot;
    logic [GEN_FLD_W-1:0]  r_hgen;

    // Control state
    logic [DEPTH_W-1:0]    r_depth,  n_depth;
    logic [DEPTH_W-1:0]    r_low,    n_low;     // lowest depth ever reached
    logic [SLOTS-1:0]      r_gvalid, n_gvalid;  // generation entry written since reset
    logic                  r_gv_q;              // gvalid sampled with the generation read
    logic [SLOT_W-1:0]     r_id;

    // Result registers
    logic                  r_strobe;
    logic [SLOT_FLD_W-1:0] r_res_slot, n_res_slot;
    logic [GEN_FLD_W-1:0]  r_res_gen,  n_res_gen;
    logic                  r_ans,      n_ans;
    logic [STAT_W-1:0]     r_stat,     n_stat;

    // Memory ports; the generation entry carries the alive bit on top
    logic                  stk_we;
    logic [SLOT_W-1:0]     stk_waddr;
    logic [SLOT_W-1:0]     stk_wdata;
    logic [SLOT_W-1:0]     stk_raddr;
    logic [SLOT_W-1:0]     stk_rdata;
    logic                  gen_we;
    logic [SLOT_W-1:0]     gen_waddr;
    logic [GEN_BITS:0]     gen_wdata;
    logic [SLOT_W-1:0]     gen_raddr;
    logic [GEN_BITS:0]     gen_rdata;

    logic [DEPTH_W-1:0]    top_idx;
    logic [SLOT_W-1:0]     pop_id;
    logic [GEN_BITS-1:0]   cur_gen;
    logic                  cur_alive;
    logic [SLOT_W-1:0]     sidx;
    logic                  is_create;
    logic                  in_range;
    logic                  gen_eq;

    assign top_idx   = r_depth - DEPTH_W'(1);
    assign is_create = (r_op == OP_CREATE) || (r_op == OP_RESERVE);
    assign o_stat.pop_go = is_create && (r_depth != '0);

    // Entries below the low mark were never pushed; their initial slot is computed, not read.
    assign pop_id = (r_low <= top_idx) ? stk_rdata : ~top_idx[SLOT_W-1:0];

    assign sidx      = r_slot[SLOT_W-1:0];
    assign in_range  = (r_slot < INVALID_SLOT);
    assign cur_gen   = r_gv_q ? gen_rdata[GEN_BITS-1:0] : '0;
    assign cur_alive = r_gv_q && gen_rdata[GEN_BITS];
    assign gen_eq    = (GEN_FLD_W'(cur_gen) == r_hgen);

    assign stk_raddr = top_idx[SLOT_W-1:0];
    assign gen_raddr = i_cmd.pop ? pop_id : i_slot[SLOT_W-1:0];

    always_comb begin
        n_depth    = r_depth;
        n_low      = r_low;
        n_gvalid   = r_gvalid;
        n_res_slot = INVALID_SLOT;
        n_res_gen  = '0;
        n_ans      = 1'b0;
        n_stat     = ST_OK;
        stk_we     = 1'b0;
        stk_waddr  = r_depth[SLOT_W-1:0];
        stk_wdata  = sidx;
        gen_we     = 1'b0;
        gen_waddr  = sidx;
        gen_wdata  = {1'b0, cur_gen + GEN_BITS'(1)};

        if (i_cmd.pop) begin
            n_depth = top_idx;
            if (top_idx < r_low) begin
                n_low = top_idx;
            end
        end

        if (i_cmd.finish_b) begin
            n_res_slot = SLOT_FLD_W'(r_id);
            n_res_gen  = GEN_FLD_W'(cur_gen);
            // create marks the popped slot alive, generation unchanged
            if (r_op == OP_CREATE) begin
                gen_we           = 1'b1;
                gen_waddr        = r_id;
                gen_wdata        = {1'b1, cur_gen};
                n_gvalid[r_id]   = 1'b1;
            end
        end

        if (i_cmd.finish_a) begin
            if (is_create) begin
                n_stat = ST_EMPTY;
            end else if (r_op > OP_GET) begin
                n_stat = ST_OK;
            end else if (r_op == OP_VALID && r_slot == INVALID_SLOT) begin
                n_stat = ST_OK;
            end else if (!in_range) begin
                n_stat = ST_RANGE;
            end else begin
                case (r_op)
                    OP_DESTROY: begin
                        if (cur_alive) begin
                            n_gvalid[sidx] = 1'b1;
                            gen_we         = 1'b1;
                            if (r_depth < FULL_DEPTH) begin
                                stk_we  = 1'b1;
                                n_depth = r_depth + DEPTH_W'(1);
                            end
                        end
                    end
                    OP_READY: begin
                        n_res_slot = r_slot;
                        n_res_gen  = GEN_FLD_W'(cur_gen);
                        n_ans      = cur_alive && gen_eq;
                    end
                    OP_VALID: begin
                        n_res_slot = r_slot;
                        n_res_gen  = GEN_FLD_W'(cur_gen);
                        n_ans      = gen_eq;
                    end
                    default: begin
                        n_res_slot = r_slot;
                        n_res_gen  = GEN_FLD_W'(cur_gen);
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_depth  <= FULL_DEPTH;
            r_low    <= FULL_DEPTH;
            r_gvalid <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_depth  <= n_depth;
            r_low    <= n_low;
            r_gvalid <= n_gvalid;
            r_strobe <= i_cmd.finish_a || i_cmd.finish_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op   <= i_op;
            r_slot <= i_slot;
            r_hgen <= i_handle_generation;
        end
        if (i_cmd.pop) begin
            r_id <= pop_id;
        end
        r_gv_q <= r_gvalid[gen_raddr];
        if (i_cmd.finish_a || i_cmd.finish_b) begin
            r_res_slot <= n_res_slot;
            r_res_gen  <= n_res_gen;
            r_ans      <= n_ans;
            r_stat     <= n_stat;
        end
    end

    gha_ram #(.WIDTH(SLOT_W), .DEPTH(SLOTS)) u_stack_ram (
        .i_clk   (i_clk),
        .i_we    (stk_we),
        .i_waddr (stk_waddr),
        .i_wdata (stk_wdata),
        .i_raddr (stk_raddr),
        .o_rdata (stk_rdata)
    );

    gha_ram #(.WIDTH(GEN_BITS + 1), .DEPTH(SLOTS)) u_gen_ram (
        .i_clk   (i_clk),
        .i_we    (gen_we),
        .i_waddr (gen_waddr),
        .i_wdata (gen_wdata),
        .i_raddr (gen_raddr),
        .o_rdata (gen_rdata)
    );

    assign o_strobe            = r_strobe;
    assign o_result_slot       = r_res_slot;
    assign o_result_generation = r_res_gen;
    assign o_answer            = r_ans;
    assign o_status            = r_stat;

endmodule

@@ src/gha_checker.sv @@
// Port-level assertions for the handle allocator and their bind.
module gha_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              start,
    input logic                              busy,
    input logic                              o_strobe,
    input logic [gha_pkg::SLOT_FLD_W-1:0]    o_result_slot,
    input logic [gha_pkg::GEN_FLD_W-1:0]     o_result_generation,
    input logic                              o_answer,
    input logic [gha_pkg::STAT_W-1:0]        o_status
);
    import gha_pkg::*;

    // A taken command raises busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after command");

    // Result strobes never come back to back.
    a_strobe_spacing: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |=> !o_strobe)
        else $error("back-to-back result strobes");

    // A result appears only once the block has gone idle.
    a_strobe_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy && $past(busy))
        else $error("result strobe while busy");

    // Error results carry the invalid handle and no answer.
    a_error_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_status != ST_OK) |->
            (o_result_slot == INVALID_SLOT && o_result_generation == '0 && !o_answer))
        else $error("error result with a live handle");

endmodule

bind generational_handle_allocator_core gha_checker u_gha_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .start               (start),
    .busy                (busy),
    .o_strobe            (o_strobe),
    .o_result_slot       (o_result_slot),
    .o_result_generation (o_result_generation),
    .o_answer            (o_answer),
    .o_status            (o_status)
);
